// ===== rtl/asb_pkg.sv =====
// ----------------------------------------------------------------------------
// asb_pkg
// Shared types, constants and the channel mix function of the ARGB4444 sprite
// alpha blender.
// ----------------------------------------------------------------------------
package asb_pkg;

  localparam logic [3:0] OPAQUE_ALPHA = 4'hF;
  localparam logic [3:0] CLEAR_ALPHA  = 4'h0;
  localparam logic [4:0] BLEND_SCALE  = 5'd16;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    REG_TARGET_FORMAT = 1'b0
  } reg_index_t;

  typedef enum logic {
    FMT_RGB565   = 1'b0,
    FMT_ARGB4444 = 1'b1
  } target_format_t;

  typedef struct packed {
    logic [3:0] src_alpha;
    logic [3:0] src_red;
    logic [3:0] src_green;
    logic [3:0] src_blue;
    logic [3:0] dst_alpha;
    logic [4:0] dst_red;
    logic [5:0] dst_green;
    logic [4:0] dst_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [3:0] out_alpha;
    logic [4:0] out_red;
    logic [5:0] out_green;
    logic [4:0] out_blue;
  } pixel_out_t;

  // (d*(16-a) + s*a) / 16, truncated; the result never exceeds max(d, s)
  function automatic logic [5:0] mix_channel(input logic [5:0] d, input logic [5:0] s,
                                             input logic [3:0] a);
    logic [10:0] sum;
    logic [4:0]  inv;
    inv = BLEND_SCALE - {1'b0, a};
    sum = 11'(d) * 11'(inv) + 11'(s) * 11'(a);
    return sum[9:4];
  endfunction

endpackage

// ===== rtl/asb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// asb_cfg_regs
// APB-style register file holding the destination format select.
// ----------------------------------------------------------------------------
module asb_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [asb_pkg::ADDR_W-1:0]    paddr,
  input  logic [asb_pkg::DATA_W-1:0]    pwdata,
  output logic [asb_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output asb_pkg::target_format_t       target_format
);

  logic                     hit;
  logic                     wr_en;
  asb_pkg::target_format_t  target_format_next;

  assign pready = 1'b1;
  assign hit    = (paddr[asb_pkg::ADDR_W-1] == asb_pkg::REG_TARGET_FORMAT);
  assign wr_en  = psel && penable && pwrite && pready && hit;

  always_comb begin
    target_format_next = target_format;
    if (wr_en) begin
      target_format_next = asb_pkg::target_format_t'(pwdata[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_format <= asb_pkg::FMT_RGB565;
    end else begin
      target_format <= target_format_next;
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata[0] = target_format;
    end
  end

endmodule

// ===== rtl/asb_blend.sv =====
// ----------------------------------------------------------------------------
// asb_blend
// Blend datapath: one sprite pixel over one destination pixel in the
// selected destination format.
// ----------------------------------------------------------------------------
module asb_blend (
  input  asb_pkg::pixel_in_t       pix,
  input  asb_pkg::target_format_t  target_format,
  output asb_pkg::pixel_out_t      result
);

  logic [5:0] d_a, d_r, d_g, d_b;
  logic [5:0] s_a, s_r, s_g, s_b;
  logic [5:0] m_a, m_r, m_g, m_b;
  logic       opaque;
  logic       clear;

  assign opaque = (pix.src_alpha == asb_pkg::OPAQUE_ALPHA);
  assign clear  = (pix.src_alpha == asb_pkg::CLEAR_ALPHA);

  always_comb begin
    d_a = {2'b00, pix.dst_alpha};
    s_a = {2'b00, pix.src_alpha};
    case (target_format)
      asb_pkg::FMT_RGB565: begin
        d_r = {1'b0, pix.dst_red};
        d_g = pix.dst_green;
        d_b = {1'b0, pix.dst_blue};
        s_r = {1'b0, pix.src_red, 1'b0};
        s_g = {pix.src_green, 2'b00};
        s_b = {1'b0, pix.src_blue, 1'b0};
      end
      default: begin
        d_r = {2'b00, pix.dst_red[3:0]};
        d_g = {2'b00, pix.dst_green[3:0]};
        d_b = {2'b00, pix.dst_blue[3:0]};
        s_r = {2'b00, pix.src_red};
        s_g = {2'b00, pix.src_green};
        s_b = {2'b00, pix.src_blue};
      end
    endcase
  end

  always_comb begin
    if (opaque) begin
      m_a = s_a;
      m_r = s_r;
      m_g = s_g;
      m_b = s_b;
    end else if (clear) begin
      m_a = d_a;
      m_r = d_r;
      m_g = d_g;
      m_b = d_b;
    end else begin
      m_a = asb_pkg::mix_channel(d_a, s_a, pix.src_alpha);
      m_r = asb_pkg::mix_channel(d_r, s_r, pix.src_alpha);
      m_g = asb_pkg::mix_channel(d_g, s_g, pix.src_alpha);
      m_b = asb_pkg::mix_channel(d_b, s_b, pix.src_alpha);
    end
  end

  always_comb begin
    case (target_format)
      asb_pkg::FMT_RGB565: begin
        result.out_alpha = 4'd0;
        result.out_red   = m_r[4:0];
        result.out_green = m_g;
        result.out_blue  = m_b[4:0];
      end
      default: begin
        result.out_alpha = m_a[3:0];
        result.out_red   = {1'b0, m_r[3:0]};
        result.out_green = {2'b00, m_g[3:0]};
        result.out_blue  = {1'b0, m_b[3:0]};
      end
    endcase
  end

endmodule

// ===== rtl/argb4444_sprite_alpha_blend.sv =====
// ----------------------------------------------------------------------------
// argb4444_sprite_alpha_blend
// Blends an ARGB4444 sprite pixel over an RGB565 or ARGB4444 destination pixel.
// ----------------------------------------------------------------------------
// Takes one pixel pair per clock and returns one blended pixel per clock
// while out_ready is high. An accepted pixel lands in the input register, is
// blended by the datapath and is captured in the result register, which
// raises out_valid; the input register stalls only with the result register,
// so in_ready stays high while the result register can move on. target_format
// is read at blend time and should only be written while no pixel is in flight.
module argb4444_sprite_alpha_blend (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  asb_pkg::pixel_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output asb_pkg::pixel_out_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [asb_pkg::ADDR_W-1:0]    paddr,
  input  logic [asb_pkg::DATA_W-1:0]    pwdata,
  output logic [asb_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  asb_pkg::target_format_t  target_format;
  asb_pkg::pixel_in_t       pix;
  asb_pkg::pixel_out_t      blended;
  logic                     pix_valid;
  logic                     pix_valid_next;
  logic                     out_valid_next;
  logic                     out_free;
  logic                     pix_move;

  asb_cfg_regs u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .target_format (target_format)
  );

  asb_blend u_blend (
    .pix           (pix),
    .target_format (target_format),
    .result        (blended)
  );

  assign out_free = !out_valid || out_ready;
  assign pix_move = pix_valid && out_free;
  assign in_ready = !pix_valid || out_free;

  always_comb begin
    pix_valid_next = pix_valid;
    if (in_valid && in_ready) begin
      pix_valid_next = 1'b1;
    end else if (pix_move) begin
      pix_valid_next = 1'b0;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (out_free) begin
      out_valid_next = pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pix_valid <= pix_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pix <= in_data;
    end
    if (pix_move) begin
      out_data <= blended;
    end
  end

  // a held input pixel keeps its contents while the result side is stalled
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !out_free |=> pix_valid && $stable(pix))
    else $error("input register changed while stalled");

  // a pending result is never overwritten by the next pixel
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result register changed while stalled");

  a_rgb565_alpha: assert property (@(posedge clk) disable iff (rst)
    out_valid && target_format == asb_pkg::FMT_RGB565 |-> out_data.out_alpha == 4'd0)
    else $error("non-zero alpha in RGB565 mode");

  a_argb_width: assert property (@(posedge clk) disable iff (rst)
    out_valid && target_format == asb_pkg::FMT_ARGB4444 |->
      out_data.out_red[4] == 1'b0 && out_data.out_green[5:4] == 2'b00 &&
      out_data.out_blue[4] == 1'b0)
    else $error("ARGB4444 result wider than four bits");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pix_valid && !out_valid)
    else $error("pipeline not empty after reset");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the ARGB4444 sprite blender against a pixel-level predictor.
// Directed pixels cover clear, opaque and partial alpha in both destination
// formats, then long random streams run, all but the last with bursty stalls
// on both channels. The format register is written and read back over APB
// between phases, and every blended pixel is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int REG_STRIDE  = 4;
  localparam logic [asb_pkg::ADDR_W-1:0] FORMAT_ADDR =
    asb_pkg::ADDR_W'(REG_STRIDE * int'(asb_pkg::REG_TARGET_FORMAT));
  // first address past the register map
  localparam logic [asb_pkg::ADDR_W-1:0] UNMAPPED_ADDR =
    FORMAT_ADDR + asb_pkg::ADDR_W'(REG_STRIDE);

  logic                       clk      = 1'b0;
  logic                       rst      = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  asb_pkg::pixel_in_t         in_data  = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b1;
  asb_pkg::pixel_out_t        out_data;
  logic                       psel     = 1'b0;
  logic                       penable  = 1'b0;
  logic                       pwrite   = 1'b0;
  logic [asb_pkg::ADDR_W-1:0] paddr    = '0;
  logic [asb_pkg::DATA_W-1:0] pwdata   = '0;
  logic [asb_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  asb_pkg::pixel_out_t     expected_pixels[$];
  asb_pkg::pixel_out_t     want_pixel;
  asb_pkg::target_format_t cur_format    = asb_pkg::FMT_RGB565;
  int             error_count   = 0;
  int             pixels_sent   = 0;
  int             pixels_checked = 0;
  int             format_writes = 0;
  int             cycle_count   = 0;
  bit             idle_allowed  = 1'b1;
  bit             send_bursty   = 1'b0;
  bit             recv_bursty   = 1'b0;

  argb4444_sprite_alpha_blend dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic int unsigned weigh(int unsigned d, int unsigned s, int unsigned a);
    return (d * (int'(asb_pkg::BLEND_SCALE) - a) + s * a) / int'(asb_pkg::BLEND_SCALE);
  endfunction

  function automatic asb_pkg::pixel_out_t blend_pixel(asb_pkg::pixel_in_t p,
                                                      asb_pkg::target_format_t fmt);
    asb_pkg::pixel_out_t r;
    int unsigned a, sa, sr, sg, sb, da, dr, dg, db, oa, orr, og, ob;
    a = p.src_alpha;
    if (fmt == asb_pkg::FMT_RGB565) begin
      // alpha channel forced to zero, sprite colour widened to 565
      sa = 0;
      da = 0;
      sr = {p.src_red, 1'b0};
      sg = {p.src_green, 2'b00};
      sb = {p.src_blue, 1'b0};
      dr = p.dst_red;
      dg = p.dst_green;
      db = p.dst_blue;
    end else begin
      sa = p.src_alpha;
      da = p.dst_alpha;
      sr = p.src_red;
      sg = p.src_green;
      sb = p.src_blue;
      dr = p.dst_red[3:0];
      dg = p.dst_green[3:0];
      db = p.dst_blue[3:0];
    end
    if (a == asb_pkg::OPAQUE_ALPHA) begin
      oa = sa; orr = sr; og = sg; ob = sb;
    end else if (a == asb_pkg::CLEAR_ALPHA) begin
      oa = da; orr = dr; og = dg; ob = db;
    end else begin
      oa  = weigh(da, sa, a);
      orr = weigh(dr, sr, a);
      og  = weigh(dg, sg, a);
      ob  = weigh(db, sb, a);
    end
    r.out_alpha = 4'(oa);
    r.out_red   = 5'(orr);
    r.out_green = 6'(og);
    r.out_blue  = 5'(ob);
    return r;
  endfunction

  function automatic asb_pkg::pixel_in_t random_pixel();
    asb_pkg::pixel_in_t p;
    logic [63:0]        bits;
    bits = {$urandom, $urandom};
    p = bits[$bits(asb_pkg::pixel_in_t)-1:0];
    case ($urandom_range(0, 7))
      0: begin
        p.src_alpha = asb_pkg::CLEAR_ALPHA;
      end
      1: begin
        p.src_alpha = asb_pkg::OPAQUE_ALPHA;
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  task automatic report(string msg);
    error_count++;
    if (error_count <= 50) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
  endtask

  task automatic send_pixel(asb_pkg::pixel_in_t p);
    if (idle_allowed && send_bursty && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_pixels.push_back(blend_pixel(p, cur_format));
    pixels_sent++;
    if ($urandom_range(0, 31) == 0) begin
      send_bursty = !send_bursty;
    end
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_transfer(bit is_write, logic [asb_pkg::ADDR_W-1:0] addr,
                              logic [asb_pkg::DATA_W-1:0] data,
                              output logic [asb_pkg::DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    if (is_write) begin
      format_writes++;
      if (addr == FORMAT_ADDR) begin
        cur_format = asb_pkg::target_format_t'(data[0]);
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_format();
    logic [asb_pkg::DATA_W-1:0] rdata;
    apb_transfer(1'b0, FORMAT_ADDR, '0, rdata);
    if (rdata !== asb_pkg::DATA_W'(cur_format)) begin
      report($sformatf("format readback got %0h want %0h", rdata, cur_format));
    end
  endtask

  task automatic write_reg(logic [asb_pkg::ADDR_W-1:0] addr,
                           logic [asb_pkg::DATA_W-1:0] data);
    logic [asb_pkg::DATA_W-1:0] unused;
    apb_transfer(1'b1, addr, data, unused);
    verify_format();
  endtask

  task automatic program_format(asb_pkg::target_format_t fmt);
    write_reg(FORMAT_ADDR, (asb_pkg::DATA_W'($urandom) & ~asb_pkg::DATA_W'(1)) |
                           asb_pkg::DATA_W'(fmt));
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report("result transfer with no pixel outstanding");
      end else begin
        want_pixel = expected_pixels.pop_front();
        pixels_checked++;
        if (out_data.out_alpha !== want_pixel.out_alpha) begin
          report($sformatf("pixel %0d alpha got %0d want %0d", pixels_checked,
                           out_data.out_alpha, want_pixel.out_alpha));
        end
        if (out_data.out_red !== want_pixel.out_red) begin
          report($sformatf("pixel %0d red got %0d want %0d", pixels_checked,
                           out_data.out_red, want_pixel.out_red));
        end
        if (out_data.out_green !== want_pixel.out_green) begin
          report($sformatf("pixel %0d green got %0d want %0d", pixels_checked,
                           out_data.out_green, want_pixel.out_green));
        end
        if (out_data.out_blue !== want_pixel.out_blue) begin
          report($sformatf("pixel %0d blue got %0d want %0d", pixels_checked,
                           out_data.out_blue, want_pixel.out_blue));
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (idle_allowed && recv_bursty && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ready <= 1'b1;
      if ($urandom_range(0, 31) == 0) begin
        recv_bursty = !recv_bursty;
      end
    end
  end

  task automatic test_reset_format();
    verify_format();
  endtask

  task automatic test_rgb565_blend();
    send_pixel(asb_pkg::pixel_in_t'{4'd0,  4'd15, 4'd15, 4'd15, 4'd15, 5'd9,  6'd33, 5'd17});
    send_pixel(asb_pkg::pixel_in_t'{4'd15, 4'd15, 4'd15, 4'd15, 4'd0,  5'd0,  6'd0,  5'd0});
    send_pixel(asb_pkg::pixel_in_t'{4'd15, 4'd0,  4'd0,  4'd0,  4'd15, 5'd31, 6'd63, 5'd31});
    send_pixel(asb_pkg::pixel_in_t'{4'd1,  4'd15, 4'd15, 4'd15, 4'd0,  5'd0,  6'd0,  5'd0});
    send_pixel(asb_pkg::pixel_in_t'{4'd14, 4'd0,  4'd0,  4'd0,  4'd0,  5'd31, 6'd63, 5'd31});
    send_pixel(asb_pkg::pixel_in_t'{4'd8,  4'd15, 4'd15, 4'd15, 4'd15, 5'd31, 6'd63, 5'd31});
    send_pixel(asb_pkg::pixel_in_t'{4'd7,  4'd10, 4'd5,  4'd3,  4'd9,  5'd20, 6'd40, 5'd12});
    send_pixel(asb_pkg::pixel_in_t'{4'd1,  4'd0,  4'd0,  4'd0,  4'd0,  5'd1,  6'd1,  5'd1});
    drain_pipeline();
  endtask

  task automatic test_format_register();
    write_reg(FORMAT_ADDR, 32'hFFFF_FFFE);
    write_reg(UNMAPPED_ADDR, 32'hFFFF_FFFF);
    write_reg(FORMAT_ADDR, 32'hFFFF_FFFF);
    write_reg(UNMAPPED_ADDR, 32'h0000_0000);
  endtask

  task automatic test_argb4444_blend();
    program_format(asb_pkg::FMT_ARGB4444);
    send_pixel(asb_pkg::pixel_in_t'{4'd0,  4'd15, 4'd15, 4'd15, 4'd9,  5'h1F, 6'h3F, 5'h1F});
    send_pixel(asb_pkg::pixel_in_t'{4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  5'h10, 6'h30, 5'h10});
    send_pixel(asb_pkg::pixel_in_t'{4'd15, 4'd3,  4'd6,  4'd9,  4'd0,  5'd31, 6'd63, 5'd31});
    send_pixel(asb_pkg::pixel_in_t'{4'd8,  4'd15, 4'd15, 4'd15, 4'd0,  5'd0,  6'd0,  5'd0});
    send_pixel(asb_pkg::pixel_in_t'{4'd14, 4'd0,  4'd0,  4'd0,  4'd15, 5'h1F, 6'h3F, 5'h1F});
    send_pixel(asb_pkg::pixel_in_t'{4'd1,  4'd15, 4'd15, 4'd15, 4'd15, 5'h10, 6'h20, 5'h10});
    send_pixel(asb_pkg::pixel_in_t'{4'd1,  4'd0,  4'd0,  4'd0,  4'd1,  5'd1,  6'd1,  5'd1});
    send_pixel(asb_pkg::pixel_in_t'{4'd6,  4'd12, 4'd7,  4'd2,  4'd11, 5'h13, 6'h2A, 5'h0C});
    drain_pipeline();
  endtask

  task automatic run_random_phase(int count, asb_pkg::target_format_t fmt);
    program_format(fmt);
    repeat (count) begin
      send_pixel(random_pixel());
      // occasionally hold off until the pipe is empty
      if ($urandom_range(0, 199) == 0) begin
        drain_pipeline();
      end
    end
    drain_pipeline();
  endtask

  task automatic test_random_stream();
    run_random_phase(300, asb_pkg::FMT_RGB565);
    run_random_phase(300, asb_pkg::FMT_ARGB4444);
    run_random_phase(300, asb_pkg::FMT_RGB565);
    run_random_phase(300, asb_pkg::FMT_ARGB4444);
    idle_allowed = 1'b0;
    run_random_phase(325, asb_pkg::target_format_t'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_format();
    test_rgb565_blend();
    test_format_register();
    test_argb4444_blend();
    test_random_stream();
    drain_pipeline();
    if (expected_pixels.size() != 0) begin
      report($sformatf("%0d pixels never returned", expected_pixels.size()));
    end
    $display("run covered %0d pixels over both destination formats and %0d register writes",
             pixels_sent, format_writes);
    $display("%0d blended results compared, %0d mismatches", pixels_checked, error_count);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
